// File: design/swv_pkg.sv
`default_nettype none

package swv_pkg;

    localparam int unsigned DUR_W  = 12;
    localparam int unsigned ADDR_W = 8;
    localparam int unsigned VOL_W  = 5;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned DATA_W = 12;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_DEVICE_ADDRESS = 3'd0;
    localparam logic [IDX_W-1:0] REG_WAKE_LOW       = 3'd1;
    localparam logic [IDX_W-1:0] REG_ENABLE_HIGH    = 3'd2;
    localparam logic [IDX_W-1:0] REG_ENABLE_LOW     = 3'd3;
    localparam logic [IDX_W-1:0] REG_MARKER         = 3'd4;
    localparam logic [IDX_W-1:0] REG_BIT_PERIOD     = 3'd5;
    localparam logic [IDX_W-1:0] REG_ONE_LOW        = 3'd6;
    localparam logic [IDX_W-1:0] REG_ZERO_LOW       = 3'd7;

    localparam logic [ADDR_W-1:0] RST_DEVICE_ADDRESS = 8'h72;
    localparam logic [DUR_W-1:0]  RST_WAKE_LOW       = 12'd2600;
    localparam logic [DUR_W-1:0]  RST_ENABLE_HIGH    = 12'd150;
    localparam logic [DUR_W-1:0]  RST_ENABLE_LOW     = 12'd300;
    localparam logic [DUR_W-1:0]  RST_MARKER         = 12'd10;
    localparam logic [DUR_W-1:0]  RST_BIT_PERIOD     = 12'd300;
    localparam logic [DUR_W-1:0]  RST_ONE_LOW        = 12'd100;
    localparam logic [DUR_W-1:0]  RST_ZERO_LOW       = 12'd200;

    typedef struct packed {
        logic [ADDR_W-1:0] device_address;
        logic [DUR_W-1:0]  wake_low;
        logic [DUR_W-1:0]  enable_high;
        logic [DUR_W-1:0]  enable_low;
        logic [DUR_W-1:0]  marker;
        logic [DUR_W-1:0]  bit_period;
        logic [DUR_W-1:0]  one_low;
        logic [DUR_W-1:0]  zero_low;
    } t_cfg;

    typedef struct packed {
        logic wire_level;
        logic busy_res;
        logic frame_done;
    } t_res;

endpackage

`default_nettype wire

// File: design/swv_in_if.sv
`default_nettype none

interface swv_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [4:0] volume_code;

    modport source (output valid, output kind, output volume_code, input ready);
    modport sink   (input valid, input kind, input volume_code, output ready);
endinterface

`default_nettype wire

// File: design/swv_out_if.sv
`default_nettype none

interface swv_out_if;
    logic valid;
    logic ready;
    logic wire_level;
    logic busy_res;
    logic frame_done;

    modport source (output valid, output wire_level, output busy_res, output frame_done,
                    input ready);
    modport sink   (input valid, input wire_level, input busy_res, input frame_done,
                    output ready);
endinterface

`default_nettype wire

// File: design/swv_core.sv
`default_nettype none

module swv_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire swv_pkg::t_cfg                 i_cfg,
    input  wire logic                          i_step,
    input  wire logic                          i_start,
    input  wire logic [swv_pkg::VOL_W-1:0]     i_volume_code,
    output swv_pkg::t_res                      o_res
);
    import swv_pkg::*;

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_WAKE       = 7'b0000010,
        PH_EN_HIGH    = 7'b0000100,
        PH_EN_LOW     = 7'b0001000,
        PH_MARK_START = 7'b0010000,
        PH_BIT        = 7'b0100000,
        PH_MARK_END   = 7'b1000000
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [DUR_W-1:0]   r_ticks, n_ticks;
    logic               r_sel, n_sel;
    logic [2:0]         r_pos, n_pos;
    logic [VOL_W-1:0]   r_vol, n_vol;
    logic               r_line, n_line;

    logic [DUR_W-1:0]   ticks_inc;
    logic [DUR_W-1:0]   phase_len;
    logic [DUR_W-1:0]   low_now;
    logic [DUR_W-1:0]   low_entry;
    logic               done;

    // low time of the bit slot at a given byte and position, MSB first
    function automatic logic [DUR_W-1:0] low_time(
        input t_cfg             cfg,
        input logic             sel,
        input logic [VOL_W-1:0] vol,
        input logic [2:0]       pos
    );
        logic [ADDR_W-1:0] byte_val;
        logic [2:0]        idx;
        byte_val = sel ? {{(ADDR_W-VOL_W){1'b0}}, vol} : cfg.device_address;
        idx      = 3'd7 - pos;
        return byte_val[idx] ? cfg.one_low : cfg.zero_low;
    endfunction

    always_comb begin
        case (r_phase)
            PH_WAKE:       phase_len = i_cfg.wake_low;
            PH_EN_HIGH:    phase_len = i_cfg.enable_high;
            PH_EN_LOW:     phase_len = i_cfg.enable_low;
            PH_MARK_START: phase_len = i_cfg.marker;
            PH_BIT:        phase_len = i_cfg.bit_period;
            PH_MARK_END:   phase_len = i_cfg.marker;
            default:       phase_len = '0;
        endcase
    end

    assign ticks_inc = r_ticks + 1'b1;
    assign low_now   = low_time(i_cfg, r_sel, r_vol, r_pos);
    // next slot: position 0 from a start marker, else one further
    assign low_entry = low_time(i_cfg, r_sel, r_vol,
                                (r_phase == PH_BIT) ? r_pos + 3'd1 : 3'd0);

    always_comb begin
        n_phase = r_phase;
        n_ticks = r_ticks;
        n_sel   = r_sel;
        n_pos   = r_pos;
        n_vol   = r_vol;
        n_line  = r_line;
        done    = 1'b0;
        if (i_step) begin
            if (i_start) begin
                n_vol   = i_volume_code;
                n_sel   = 1'b0;
                n_pos   = 3'd0;
                n_phase = PH_WAKE;
                n_ticks = '0;
                n_line  = 1'b0;
            end else if (r_phase != PH_IDLE) begin
                n_ticks = ticks_inc;
                if (ticks_inc >= phase_len) begin
                    n_ticks = '0;
                    case (r_phase)
                        PH_WAKE: begin
                            n_phase = PH_EN_HIGH;
                            n_line  = 1'b1;
                        end
                        PH_EN_HIGH: begin
                            n_phase = PH_EN_LOW;
                            n_line  = 1'b0;
                        end
                        PH_EN_LOW: begin
                            n_phase = PH_MARK_START;
                            n_line  = 1'b1;
                        end
                        PH_MARK_START: begin
                            n_pos   = 3'd0;
                            n_phase = PH_BIT;
                            n_line  = (low_entry == '0);
                        end
                        PH_BIT: begin
                            if (r_pos == 3'd7) begin
                                n_phase = PH_MARK_END;
                                n_line  = 1'b0;
                            end else begin
                                n_pos   = r_pos + 3'd1;
                                n_phase = PH_BIT;
                                n_line  = (low_entry == '0);
                            end
                        end
                        PH_MARK_END: begin
                            if (r_sel) begin
                                n_phase = PH_IDLE;
                                n_line  = 1'b1;
                                done    = 1'b1;
                            end else begin
                                n_sel   = 1'b1;
                                n_phase = PH_MARK_START;
                                n_line  = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_line  = 1'b1;
                        end
                    endcase
                end else if (r_phase == PH_BIT) begin
                    n_line = (ticks_inc >= low_now);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ticks <= '0;
            r_sel   <= 1'b0;
            r_pos   <= 3'd0;
            r_vol   <= '0;
            r_line  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_sel   <= n_sel;
            r_pos   <= n_pos;
            r_vol   <= n_vol;
            r_line  <= n_line;
        end
    end

    assign o_res.wire_level = n_line;
    assign o_res.busy_res   = (n_phase != PH_IDLE);
    assign o_res.frame_done = done;

endmodule

`default_nettype wire

// File: design/single_wire_volume_transmitter.sv
`default_nettype none

// Single-wire volume line driver. Every input beat is one item: a start
// (kind 1) latches the volume code and restarts the frame from the wake low,
// a tick (kind 0) advances the frame by one microsecond. Each beat yields one
// result beat with the line level, busy and a done pulse on the tick that
// ends the frame. One beat is taken every clock while the skid entry is free:
// the frame counter update is a single 12-bit increment and compare, and a
// two-entry output buffer keeps the input flowing while a result waits.
// Registers are written via i_cfg_we / i_cfg_idx / i_cfg_data and used live.
module single_wire_volume_transmitter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [swv_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire logic [swv_pkg::DATA_W-1:0]    i_cfg_data,
    swv_in_if.sink                             i_in,
    swv_out_if.source                          o_out
);
    import swv_pkg::*;

    t_cfg  r_cfg;
    t_res  res;
    t_res  r_out, n_out;
    t_res  r_skid, n_skid;
    logic  r_out_valid, n_out_valid;
    logic  r_skid_valid, n_skid_valid;
    logic  in_acc;
    logic  out_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= RST_DEVICE_ADDRESS;
            r_cfg.wake_low       <= RST_WAKE_LOW;
            r_cfg.enable_high    <= RST_ENABLE_HIGH;
            r_cfg.enable_low     <= RST_ENABLE_LOW;
            r_cfg.marker         <= RST_MARKER;
            r_cfg.bit_period     <= RST_BIT_PERIOD;
            r_cfg.one_low        <= RST_ONE_LOW;
            r_cfg.zero_low       <= RST_ZERO_LOW;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg_data[ADDR_W-1:0];
                REG_WAKE_LOW:       r_cfg.wake_low       <= i_cfg_data[DUR_W-1:0];
                REG_ENABLE_HIGH:    r_cfg.enable_high    <= i_cfg_data[DUR_W-1:0];
                REG_ENABLE_LOW:     r_cfg.enable_low     <= i_cfg_data[DUR_W-1:0];
                REG_MARKER:         r_cfg.marker         <= i_cfg_data[DUR_W-1:0];
                REG_BIT_PERIOD:     r_cfg.bit_period     <= i_cfg_data[DUR_W-1:0];
                REG_ONE_LOW:        r_cfg.one_low        <= i_cfg_data[DUR_W-1:0];
                REG_ZERO_LOW:       r_cfg.zero_low       <= i_cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = !r_skid_valid;
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_fire   = o_out.valid && o_out.ready;

    swv_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_step        (in_acc),
        .i_start       (i_in.kind),
        .i_volume_code (i_in.volume_code),
        .o_res         (res)
    );

    // output register plus skid entry
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || out_fire) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = res;
                n_out_valid = in_acc;
            end
        end else if (in_acc) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.wire_level = r_out.wire_level;
    assign o_out.busy_res   = r_out.busy_res;
    assign o_out.frame_done = r_out.frame_done;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without a result in the output register");

    a_done_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_done) |-> (!o_out.busy_res && o_out.wire_level))
        else $error("frame done beat must show an idle high line");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_out_valid && !o_out.ready) |=> r_skid_valid)
        else $error("beat taken under stall was not kept in the skid entry");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.kind) |-> (res.busy_res && !res.wire_level && !res.frame_done))
        else $error("start beat must open the wake low");

endmodule

`default_nettype wire
